FILE: hdl/erc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the empty-retry circuit breaker.
// No dependencies; used by the front end, back end and top level.
package erc_pkg;

  typedef enum logic [1:0] {
    KIND_OUTCOME = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OC_SUCCESS   = 2'd0,
    OC_EMPTY     = 2'd1,
    OC_EXCEPTION = 2'd2,
    OC_UNKNOWN   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    ST_DUPLICATE   = 4'd0,
    ST_SUCCESS     = 4'd1,
    ST_RETRY       = 4'd2,
    ST_OPENED      = 4'd3,
    ST_REJECTED    = 4'd4,
    ST_EXCEPTION   = 4'd5,
    ST_UNKNOWN     = 4'd6,
    ST_ACK_TAKEN   = 4'd7,
    ST_ACK_IGNORED = 4'd8,
    ST_TICK        = 4'd9
  } status_t;

  // Input func codes
  localparam logic [1:0] FUNC_OUTCOME = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;

  // Configuration register indexes
  localparam logic [7:0] REG_EMPTY_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_DEGRADE_TIMEOUT = 8'd1;
  localparam logic [7:0] REG_RESET_WINDOW    = 8'd2;
  localparam logic [7:0] REG_DEDUP_WINDOW    = 8'd3;

  // Configuration reset values
  localparam logic [7:0]  THRESHOLD_RESET       = 8'd2;
  localparam logic [15:0] DEGRADE_TIMEOUT_RESET = 16'd800;
  localparam logic [15:0] RESET_WINDOW_RESET    = 16'd3000;
  localparam logic [15:0] DEDUP_WINDOW_RESET    = 16'd10;

  typedef struct packed {
    logic [7:0]  empty_threshold;
    logic [15:0] req_timeout_ms;
    logic [15:0] quiet_window_ms;
    logic [15:0] repeat_window_ms;
  } cfg_t;

  // Classified word passed from front end to back end (task id travels apart)
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now_ms;
    outcome_t    outcome;
    logic        ack_ok;
    logic        ack_has_task;
    logic        ack_has_request;
    logic [31:0] ack_request_id;
  } item_t;

  // Result word (blocked task id travels apart)
  typedef struct packed {
    status_t     status;
    logic        breaker_is_open;
    logic [7:0]  empty_count;
    logic        degrade_sent;
    logic        degrade_waiting;
    logic        degrade_timed_out;
    logic [31:0] request_number;
  } result_t;

endpackage

FILE: hdl/empty_retry_circuit_breaker_core.sv
`timescale 1ns / 1ps
// Top level of the empty-retry circuit breaker.
// Depends on erc_pkg, erc_front, erc_fifo and erc_back.
//
// The block takes one word per clock on its push/full side while full is low and
// returns exactly one result word per input word, in order, on its empty/pop side.
// Sustained rate is one word per cycle while neither side stalls; the whole breaker
// update (timeout check, window reset, dedup, streak count, degrade issue or ack
// match) is done combinationally by the back end and registered when the word is
// taken. A pushed word is captured in the front register, moves to a two-entry middle
// queue, is processed and lands in a two-entry result queue, where empty falls.
// Either side may stall on its own: full rises only once the front register, the
// middle queue and the result queue have all backed up. Configuration writes are
// registered and must only be made while no word is in flight.
module empty_retry_circuit_breaker_core #(
  parameter int TASK_ID_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // input side
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              func,
  input  logic [31:0]             now_ms,
  input  logic [TASK_ID_BITS-1:0] task_id,
  input  logic [1:0]              outcome,
  input  logic                    ack_ok,
  input  logic                    ack_has_task,
  input  logic                    ack_has_request,
  input  logic [31:0]             ack_request_id,
  // result side
  output logic                    empty,
  input  logic                    pop,
  output logic [3:0]              status,
  output logic                    breaker_is_open,
  output logic [7:0]              empty_count,
  output logic                    degrade_sent,
  output logic                    degrade_waiting,
  output logic                    degrade_timed_out,
  output logic [31:0]             request_number,
  output logic [TASK_ID_BITS-1:0] blocked_task,
  // configuration
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int ITEM_W = $bits(erc_pkg::item_t);
  localparam int RES_W  = $bits(erc_pkg::result_t);
  localparam int MID_W  = ITEM_W + TASK_ID_BITS;
  localparam int OUT_W  = RES_W + TASK_ID_BITS;

  erc_pkg::cfg_t           cfg;

  logic                    fwd_valid;
  erc_pkg::item_t          fwd_item;
  logic [TASK_ID_BITS-1:0] fwd_task;
  logic                    mid_full;
  logic                    mid_empty;
  logic [MID_W-1:0]        mid_rd;
  erc_pkg::item_t          mid_item;
  logic [TASK_ID_BITS-1:0] mid_task;

  logic                    back_take;
  erc_pkg::result_t        back_res;
  logic [TASK_ID_BITS-1:0] back_blocked;
  logic                    res_full;
  logic [OUT_W-1:0]        res_rd;
  erc_pkg::result_t        res_head;

  // Configuration registers: hold reset values until written, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_threshold  <= erc_pkg::THRESHOLD_RESET;
      cfg.req_timeout_ms   <= erc_pkg::DEGRADE_TIMEOUT_RESET;
      cfg.quiet_window_ms  <= erc_pkg::RESET_WINDOW_RESET;
      cfg.repeat_window_ms <= erc_pkg::DEDUP_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        erc_pkg::REG_EMPTY_THRESHOLD: cfg.empty_threshold  <= cfg_data[7:0];
        erc_pkg::REG_DEGRADE_TIMEOUT: cfg.req_timeout_ms   <= cfg_data;
        erc_pkg::REG_RESET_WINDOW:    cfg.quiet_window_ms  <= cfg_data;
        erc_pkg::REG_DEDUP_WINDOW:    cfg.repeat_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: capture and classify incoming words
  erc_front #(
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .func           (func),
    .now_ms         (now_ms),
    .task_id        (task_id),
    .outcome        (outcome),
    .ack_ok         (ack_ok),
    .ack_has_task   (ack_has_task),
    .ack_has_request(ack_has_request),
    .ack_request_id (ack_request_id),
    .fwd_valid      (fwd_valid),
    .fwd_ready      (!mid_full),
    .fwd_item       (fwd_item),
    .fwd_task       (fwd_task)
  );

  // Middle queue decouples classification from the state update
  erc_fifo #(
    .WIDTH(MID_W),
    .DEPTH(2)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fwd_valid),
    .wr_data({fwd_task, fwd_item}),
    .full   (mid_full),
    .rd_en  (back_take),
    .rd_data(mid_rd),
    .empty  (mid_empty)
  );

  assign mid_item = erc_pkg::item_t'(mid_rd[ITEM_W-1:0]);
  assign mid_task = mid_rd[MID_W-1:ITEM_W];

  // Back end: advance breaker state one word per cycle while the result queue has room
  erc_back #(
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (!mid_empty),
    .in_take    (back_take),
    .in_item    (mid_item),
    .in_task    (mid_task),
    .out_ready  (!res_full),
    .out_res    (back_res),
    .out_blocked(back_blocked)
  );

  // Result queue: hold finished words until popped
  erc_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (back_take),
    .wr_data({back_blocked, back_res}),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_rd),
    .empty  (empty)
  );

  assign res_head          = erc_pkg::result_t'(res_rd[RES_W-1:0]);
  assign status            = res_head.status;
  assign breaker_is_open   = res_head.breaker_is_open;
  assign empty_count       = res_head.empty_count;
  assign degrade_sent      = res_head.degrade_sent;
  assign degrade_waiting   = res_head.degrade_waiting;
  assign degrade_timed_out = res_head.degrade_timed_out;
  assign request_number    = res_head.request_number;
  assign blocked_task      = res_rd[OUT_W-1:RES_W];

endmodule

FILE: hdl/erc_fifo.sv
`timescale 1ns / 1ps
// Small register-based queue used between the pipeline parts.
// Generic; no package dependency.
module erc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == LIMIT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/erc_front.sv
`timescale 1ns / 1ps
// Front end: input register that takes words and classifies them.
// Depends on erc_pkg.
module erc_front #(
  parameter int TASK_ID_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              func,
  input  logic [31:0]             now_ms,
  input  logic [TASK_ID_BITS-1:0] task_id,
  input  logic [1:0]              outcome,
  input  logic                    ack_ok,
  input  logic                    ack_has_task,
  input  logic                    ack_has_request,
  input  logic [31:0]             ack_request_id,
  output logic                    fwd_valid,
  input  logic                    fwd_ready,
  output erc_pkg::item_t          fwd_item,
  output logic [TASK_ID_BITS-1:0] fwd_task
);

  logic                    valid;
  erc_pkg::item_t          item;
  logic [TASK_ID_BITS-1:0] task_q;
  erc_pkg::kind_t          kind;
  logic                    load;

  // Unused func code three behaves as a tick
  always_comb begin
    case (func)
      erc_pkg::FUNC_OUTCOME: kind = erc_pkg::KIND_OUTCOME;
      erc_pkg::FUNC_ACK:     kind = erc_pkg::KIND_ACK;
      default:               kind = erc_pkg::KIND_TICK;
    endcase
  end

  assign full      = valid && !fwd_ready;
  assign load      = push && !full;
  assign fwd_valid = valid;
  assign fwd_item  = item;
  assign fwd_task  = task_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (fwd_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.kind            <= kind;
      item.now_ms          <= now_ms;
      item.outcome         <= erc_pkg::outcome_t'(outcome);
      item.ack_ok          <= ack_ok;
      item.ack_has_task    <= ack_has_task;
      item.ack_has_request <= ack_has_request;
      item.ack_request_id  <= ack_request_id;
      task_q               <= task_id;
    end
  end

endmodule

FILE: hdl/erc_back.sv
`timescale 1ns / 1ps
// Back end: breaker state, dedup, streak counting and degrade tracking.
// Depends on erc_pkg.
module erc_back #(
  parameter int TASK_ID_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  erc_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_take,
  input  erc_pkg::item_t          in_item,
  input  logic [TASK_ID_BITS-1:0] in_task,
  input  logic                    out_ready,
  output erc_pkg::result_t        out_res,
  output logic [TASK_ID_BITS-1:0] out_blocked
);

  logic                    seen_any;
  logic [31:0]             prev_time;
  logic [TASK_ID_BITS-1:0] prev_task;
  erc_pkg::outcome_t       prev_outcome;
  logic [7:0]              empties;
  logic [TASK_ID_BITS-1:0] streak_task;
  logic                    streak_task_valid;
  logic                    empty_time_valid;
  logic [31:0]             empty_time;
  logic                    open_flag;
  logic [TASK_ID_BITS-1:0] blocked_id;
  logic                    blocked_valid;
  logic                    pending_flag;
  logic [31:0]             pending_id;
  logic [31:0]             issued_counter;
  logic [31:0]             issue_time;

  logic                    seen_any_next;
  logic [31:0]             prev_time_next;
  logic [TASK_ID_BITS-1:0] prev_task_next;
  erc_pkg::outcome_t       prev_outcome_next;
  logic [7:0]              empties_next;
  logic [TASK_ID_BITS-1:0] streak_task_next;
  logic                    streak_task_valid_next;
  logic                    empty_time_valid_next;
  logic [31:0]             empty_time_next;
  logic                    open_flag_next;
  logic [TASK_ID_BITS-1:0] blocked_id_next;
  logic                    blocked_valid_next;
  logic                    pending_flag_next;
  logic [31:0]             pending_id_next;
  logic [31:0]             issued_counter_next;
  logic [31:0]             issue_time_next;

  logic              timed_out;
  logic              window_reset;
  logic              dup;
  logic              issued;
  logic              ack_match;
  logic [31:0]       dedup_diff;
  erc_pkg::status_t  status;

  // Forward difference, read as signed, is non-negative and reaches limit
  function automatic logic elapsed_ge(input logic [31:0] now, input logic [31:0] since,
                                      input logic [15:0] limit);
    logic [31:0] d;
    d = now - since;
    return !d[31] && (d >= {16'd0, limit});
  endfunction

  assign in_take = in_valid && out_ready;

  assign timed_out    = pending_flag &&
                        elapsed_ge(in_item.now_ms, issue_time, cfg.req_timeout_ms);
  assign window_reset = empty_time_valid && (cfg.quiet_window_ms != '0) &&
                        elapsed_ge(in_item.now_ms, empty_time, cfg.quiet_window_ms);
  assign dedup_diff   = in_item.now_ms - prev_time;
  assign dup          = seen_any && !dedup_diff[31] &&
                        (dedup_diff <= {16'd0, cfg.repeat_window_ms}) &&
                        (in_task == prev_task) && (in_item.outcome == prev_outcome);
  assign ack_match    = in_item.ack_ok &&
                        !(in_item.ack_has_task && (!blocked_valid || in_task != blocked_id)) &&
                        !(in_item.ack_has_request && in_item.ack_request_id != pending_id);

  always_comb begin
    seen_any_next          = seen_any;
    prev_time_next         = prev_time;
    prev_task_next         = prev_task;
    prev_outcome_next      = prev_outcome;
    empties_next           = empties;
    streak_task_next       = streak_task;
    streak_task_valid_next = streak_task_valid;
    empty_time_valid_next  = empty_time_valid;
    empty_time_next        = empty_time;
    open_flag_next         = open_flag;
    blocked_id_next        = blocked_id;
    blocked_valid_next     = blocked_valid;
    pending_flag_next      = pending_flag && !timed_out;
    pending_id_next        = pending_id;
    issued_counter_next    = issued_counter;
    issue_time_next        = issue_time;
    issued                 = 1'b0;
    status                 = erc_pkg::ST_TICK;

    case (in_item.kind)
      erc_pkg::KIND_OUTCOME: begin
        if (window_reset) begin
          empties_next           = '0;
          open_flag_next         = 1'b0;
          blocked_valid_next     = 1'b0;
          blocked_id_next        = '0;
          streak_task_valid_next = 1'b0;
          empty_time_valid_next  = 1'b0;
        end
        if (dup) begin
          status = erc_pkg::ST_DUPLICATE;
        end else begin
          seen_any_next     = 1'b1;
          prev_time_next    = in_item.now_ms;
          prev_task_next    = in_task;
          prev_outcome_next = in_item.outcome;
          case (in_item.outcome)
            erc_pkg::OC_SUCCESS: begin
              empties_next           = '0;
              empty_time_valid_next  = 1'b0;
              streak_task_valid_next = 1'b0;
              status                 = erc_pkg::ST_SUCCESS;
            end
            erc_pkg::OC_EXCEPTION: status = erc_pkg::ST_EXCEPTION;
            erc_pkg::OC_UNKNOWN:   status = erc_pkg::ST_UNKNOWN;
            erc_pkg::OC_EMPTY: begin
              // A different task starts a fresh streak
              if (!streak_task_valid_next || streak_task != in_task) begin
                empties_next          = '0;
                empty_time_valid_next = 1'b0;
              end
              streak_task_next       = in_task;
              streak_task_valid_next = 1'b1;
              if (open_flag_next && blocked_valid_next && blocked_id_next == in_task) begin
                status = erc_pkg::ST_REJECTED;
              end else begin
                if (empties_next != 8'hFF) begin
                  empties_next = empties_next + 8'd1;
                end
                empty_time_valid_next = 1'b1;
                empty_time_next       = in_item.now_ms;
                if (empties_next < cfg.empty_threshold) begin
                  status = erc_pkg::ST_RETRY;
                end else begin
                  open_flag_next      = 1'b1;
                  blocked_id_next     = in_task;
                  blocked_valid_next  = 1'b1;
                  pending_flag_next   = 1'b1;
                  issued_counter_next = issued_counter + 32'd1;
                  pending_id_next     = issued_counter + 32'd1;
                  issue_time_next     = in_item.now_ms;
                  issued              = 1'b1;
                  status              = erc_pkg::ST_OPENED;
                end
              end
            end
            default: status = erc_pkg::ST_UNKNOWN;
          endcase
        end
      end
      erc_pkg::KIND_ACK: begin
        if (pending_flag_next && ack_match) begin
          pending_flag_next = 1'b0;
          status            = erc_pkg::ST_ACK_TAKEN;
        end else begin
          status = erc_pkg::ST_ACK_IGNORED;
        end
      end
      default: status = erc_pkg::ST_TICK;
    endcase
  end

  always_comb begin
    out_res.status            = status;
    out_res.breaker_is_open   = open_flag_next;
    out_res.empty_count       = empties_next;
    out_res.degrade_sent      = issued;
    out_res.degrade_waiting   = pending_flag_next;
    out_res.degrade_timed_out = timed_out;
    out_res.request_number    = pending_id_next;
    out_blocked               = blocked_valid_next ? blocked_id_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any          <= 1'b0;
      prev_time         <= '0;
      prev_task         <= '0;
      prev_outcome      <= erc_pkg::OC_SUCCESS;
      empties           <= '0;
      streak_task       <= '0;
      streak_task_valid <= 1'b0;
      empty_time_valid  <= 1'b0;
      empty_time        <= '0;
      open_flag         <= 1'b0;
      blocked_id        <= '0;
      blocked_valid     <= 1'b0;
      pending_flag      <= 1'b0;
      pending_id        <= '0;
      issued_counter    <= '0;
      issue_time        <= '0;
    end else if (in_take) begin
      seen_any          <= seen_any_next;
      prev_time         <= prev_time_next;
      prev_task         <= prev_task_next;
      prev_outcome      <= prev_outcome_next;
      empties           <= empties_next;
      streak_task       <= streak_task_next;
      streak_task_valid <= streak_task_valid_next;
      empty_time_valid  <= empty_time_valid_next;
      empty_time        <= empty_time_next;
      open_flag         <= open_flag_next;
      blocked_id        <= blocked_id_next;
      blocked_valid     <= blocked_valid_next;
      pending_flag      <= pending_flag_next;
      pending_id        <= pending_id_next;
      issued_counter    <= issued_counter_next;
      issue_time        <= issue_time_next;
    end
  end

endmodule

FILE: tb/empty_retry_circuit_breaker_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for empty_retry_circuit_breaker_core.
// Depends on erc_pkg and the core RTL; a local predictor checks every result word.
module empty_retry_circuit_breaker_core_tb;

  // Spare func code; the core treats it as a tick.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // One input word as the core sees it.
  typedef struct {
    logic [1:0]        func;
    logic [31:0]       now;
    logic [15:0]       tid;
    erc_pkg::outcome_t oc;
    logic              ok;
    logic              has_task;
    logic              has_req;
    logic [31:0]       req;
  } event_t;

  // One result word, field by field.
  typedef struct {
    erc_pkg::status_t st;
    logic             is_open;
    logic [7:0]       cnt;
    logic             issued;
    logic             waiting;
    logic             expired;
    logic [31:0]      reqno;
    logic [15:0]      blocked;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic [15:0] task_id;
  logic [1:0]  outcome;
  logic        ack_ok;
  logic        ack_has_task;
  logic        ack_has_request;
  logic [31:0] ack_request_id;
  logic        empty;
  logic        pop;
  logic [3:0]  status;
  logic        breaker_is_open;
  logic [7:0]  empty_count;
  logic        degrade_sent;
  logic        degrade_waiting;
  logic        degrade_timed_out;
  logic [31:0] request_number;
  logic [15:0] blocked_task;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  empty_retry_circuit_breaker_core u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .func(func), .now_ms(now_ms), .task_id(task_id), .outcome(outcome),
    .ack_ok(ack_ok), .ack_has_task(ack_has_task), .ack_has_request(ack_has_request),
    .ack_request_id(ack_request_id),
    .empty(empty), .pop(pop),
    .status(status), .breaker_is_open(breaker_is_open), .empty_count(empty_count),
    .degrade_sent(degrade_sent), .degrade_waiting(degrade_waiting),
    .degrade_timed_out(degrade_timed_out), .request_number(request_number),
    .blocked_task(blocked_task),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Breaker predictor: own copy of the configuration and the breaker state.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_thresh;
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_window;
  logic [15:0] cfg_dedup;

  logic              last_seen;    // an outcome has been accepted before
  logic [31:0]       last_ms;      // time, task and outcome of that outcome
  logic [15:0]       last_task;
  erc_pkg::outcome_t last_oc;
  logic [7:0]        streak_cnt;   // consecutive empties of the streak owner
  logic [15:0]       owner;
  logic              owner_ok;
  logic              quiet_ok;     // quiet_ms holds the last counted empty
  logic [31:0]       quiet_ms;
  logic              tripped;
  logic [15:0]       hold_task;
  logic              hold_ok;
  logic              req_open;     // degrade request waiting for its ack
  logic [31:0]       req_id;
  logic [31:0]       req_count;
  logic [31:0]       req_ms;

  // Expected result words, oldest first.
  verdict_t    verdicts[$];
  int          fails;

  function automatic void breaker_clear();
    cfg_thresh  = erc_pkg::THRESHOLD_RESET;
    cfg_timeout = erc_pkg::DEGRADE_TIMEOUT_RESET;
    cfg_window  = erc_pkg::RESET_WINDOW_RESET;
    cfg_dedup   = erc_pkg::DEDUP_WINDOW_RESET;
    last_seen = 1'b0; last_ms = '0; last_task = '0; last_oc = erc_pkg::OC_SUCCESS;
    streak_cnt = '0; owner = '0; owner_ok = 1'b0;
    quiet_ok = 1'b0; quiet_ms = '0;
    tripped = 1'b0; hold_task = '0; hold_ok = 1'b0;
    req_open = 1'b0; req_id = '0; req_count = '0; req_ms = '0;
  endfunction

  // Elapsed time read as signed 32-bit: true when non-negative and at least lim.
  function automatic bit aged(input logic [31:0] now, input logic [31:0] since,
                              input logic [31:0] lim);
    logic [31:0] d;
    d = now - since;
    return !d[31] && d >= lim;
  endfunction

  function automatic erc_pkg::status_t judge_outcome(input event_t e, output logic issued);
    logic [31:0] d;
    issued = 1'b0;
    // quiet long enough since the last counted empty: clear streak and breaker
    if (quiet_ok && cfg_window != '0 && aged(e.now, quiet_ms, {16'h0, cfg_window})) begin
      streak_cnt = '0;
      tripped    = 1'b0;
      hold_ok    = 1'b0;
      hold_task  = '0;
      owner_ok   = 1'b0;
      quiet_ok   = 1'b0;
    end
    d = e.now - last_ms;
    if (last_seen && !d[31] && d <= {16'h0, cfg_dedup} &&
        e.tid == last_task && e.oc == last_oc)
      return erc_pkg::ST_DUPLICATE;
    last_seen = 1'b1;
    last_ms   = e.now;
    last_task = e.tid;
    last_oc   = e.oc;
    case (e.oc)
      erc_pkg::OC_SUCCESS: begin
        streak_cnt = '0;
        quiet_ok   = 1'b0;
        owner_ok   = 1'b0;
        return erc_pkg::ST_SUCCESS;
      end
      erc_pkg::OC_EXCEPTION: return erc_pkg::ST_EXCEPTION;
      erc_pkg::OC_UNKNOWN:   return erc_pkg::ST_UNKNOWN;
      default: ;
    endcase
    // empty: a new task starts a fresh streak
    if (!owner_ok || owner != e.tid) begin
      owner      = e.tid;
      owner_ok   = 1'b1;
      streak_cnt = '0;
      quiet_ok   = 1'b0;
    end
    if (tripped && hold_ok && hold_task == e.tid)
      return erc_pkg::ST_REJECTED;
    if (streak_cnt != 8'hFF)
      streak_cnt++;
    quiet_ok = 1'b1;
    quiet_ms = e.now;
    if (streak_cnt < cfg_thresh)
      return erc_pkg::ST_RETRY;
    tripped   = 1'b1;
    hold_task = e.tid;
    hold_ok   = 1'b1;
    req_open  = 1'b1;
    req_count = req_count + 32'd1;
    req_id    = req_count;
    req_ms    = e.now;
    issued    = 1'b1;
    return erc_pkg::ST_OPENED;
  endfunction

  function automatic verdict_t breaker_predict(input event_t e);
    verdict_t v;
    v.issued  = 1'b0;
    v.expired = 1'b0;
    // expiry is checked first, on every kind of word
    if (req_open && aged(e.now, req_ms, {16'h0, cfg_timeout})) begin
      req_open  = 1'b0;
      v.expired = 1'b1;
    end
    if (e.func == erc_pkg::FUNC_OUTCOME)
      v.st = judge_outcome(e, v.issued);
    else if (e.func == erc_pkg::FUNC_ACK) begin
      if (!e.ok || !req_open)
        v.st = erc_pkg::ST_ACK_IGNORED;
      else if (e.has_task && (!hold_ok || e.tid != hold_task))
        v.st = erc_pkg::ST_ACK_IGNORED;
      else if (e.has_req && e.req != req_id)
        v.st = erc_pkg::ST_ACK_IGNORED;
      else begin
        req_open = 1'b0;
        v.st     = erc_pkg::ST_ACK_TAKEN;
      end
    end else
      v.st = erc_pkg::ST_TICK;
    v.is_open = tripped;
    v.cnt     = streak_cnt;
    v.waiting = req_open;
    v.reqno   = req_id;
    v.blocked = hold_ok ? hold_task : '0;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------
  function automatic event_t outcome_ev(input logic [1:0] kind, input logic [31:0] t,
                                        input logic [15:0] id,
                                        input erc_pkg::outcome_t oc);
    event_t e;
    e.func = kind; e.now = t; e.tid = id; e.oc = oc;
    e.ok = 1'b0; e.has_task = 1'b0; e.has_req = 1'b0; e.req = '0;
    return e;
  endfunction

  function automatic event_t ack_ev(input logic [31:0] t, input logic [15:0] id,
                                    input logic ok, input logic ht, input logic hr,
                                    input logic [31:0] rq);
    event_t e;
    e.func = erc_pkg::FUNC_ACK; e.now = t; e.tid = id; e.oc = erc_pkg::OC_SUCCESS;
    e.ok = ok; e.has_task = ht; e.has_req = hr; e.req = rq;
    return e;
  endfunction

  // Random traffic state: wall clock and step sizes tuned to the current windows.
  logic [31:0] wall_ms;
  int unsigned step_max;
  int unsigned jump_max;

  function automatic event_t rand_event();
    event_t e;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 75)      wall_ms = wall_ms + $urandom_range(0, step_max);
    else if (r < 87) wall_ms = wall_ms + $urandom_range(0, jump_max);
    else if (r < 97) wall_ms = wall_ms - $urandom_range(1, step_max + 1);
    else             wall_ms = $urandom;
    e.now = wall_ms;
    // mostly a handful of tasks so streaks and duplicates actually form
    e.tid = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45)      e.oc = erc_pkg::OC_EMPTY;
    else if (r < 70) e.oc = erc_pkg::OC_SUCCESS;
    else if (r < 85) e.oc = erc_pkg::OC_EXCEPTION;
    else             e.oc = erc_pkg::OC_UNKNOWN;
    r = $urandom_range(0, 99);
    if (r < 62)      e.func = erc_pkg::FUNC_OUTCOME;
    else if (r < 85) e.func = erc_pkg::FUNC_ACK;
    else if (r < 97) e.func = erc_pkg::KIND_TICK;
    else             e.func = FUNC_SPARE;
    e.ok       = 1'($urandom_range(0, 9) != 0);
    e.has_task = 1'($urandom);
    e.has_req  = 1'($urandom);
    e.req      = $urandom;
    if (e.func == erc_pkg::FUNC_ACK) begin
      // aim most acks at the live request and the blocked task
      if (e.has_task && $urandom_range(0, 9) < 8) e.tid = hold_task;
      if ($urandom_range(0, 9) < 8) e.req = req_id;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  bit paced;
  int burst_left;

  // Offer one word and hold it until the core takes it; predict on acceptance.
  task automatic send_event(input event_t e);
    verdict_t v;
    push            <= 1'b1;
    func            <= e.func;
    now_ms          <= e.now;
    task_id         <= e.tid;
    outcome         <= e.oc;
    ack_ok          <= e.ok;
    ack_has_task    <= e.has_task;
    ack_has_request <= e.has_req;
    ack_request_id  <= e.req;
    do @(posedge clk); while (full !== 1'b0);
    v = breaker_predict(e);
    verdicts.insert(verdicts.size(), v);
  endtask

  // Send in bursts of random length with random gaps between them.
  task automatic send_paced(input event_t e);
    int gap;
    send_event(e);
    if (!paced) return;
    if (burst_left != 0)
      burst_left--;
    else begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop push and hold until every outstanding word has come back.
  task automatic settle();
    push <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back while the core is idle.
  task automatic set_regs(input logic [7:0] th, input logic [15:0] tmo,
                          input logic [15:0] win, input logic [15:0] ddp);
    logic [7:0]  idxs[4];
    logic [15:0] vals[4];
    int          i;
    idxs = '{erc_pkg::REG_EMPTY_THRESHOLD, erc_pkg::REG_DEGRADE_TIMEOUT,
             erc_pkg::REG_RESET_WINDOW, erc_pkg::REG_DEDUP_WINDOW};
    vals = '{{8'h00, th}, tmo, win, ddp};
    settle();
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_thresh  = th;
    cfg_timeout = tmo;
    cfg_window  = win;
    cfg_dedup   = ddp;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: own stall pattern plus long hold-offs on request.
  // ---------------------------------------------------------------------------
  int hold_cycles;
  int rx_mode;
  int rx_left;

  always @(posedge clk) begin : rx
    verdict_t got;
    verdict_t want;
    if (!rst && pop && !empty) begin
      got.st      = erc_pkg::status_t'(status);
      got.is_open = breaker_is_open;
      got.cnt     = empty_count;
      got.issued  = degrade_sent;
      got.waiting = degrade_waiting;
      got.expired = degrade_timed_out;
      got.reqno   = request_number;
      got.blocked = blocked_task;
      if (verdicts.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result word with nothing expected, status=%0d", $time, status);
      end else begin
        want = verdicts.pop_front();
        if (got.st !== want.st || got.is_open !== want.is_open ||
            got.cnt !== want.cnt || got.issued !== want.issued ||
            got.waiting !== want.waiting || got.expired !== want.expired ||
            got.reqno !== want.reqno || got.blocked !== want.blocked) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: mismatch", $time);
            $display("  want st=%0d open=%0b cnt=%0d iss=%0b wait=%0b tmo=%0b req=%0d blk=%0h",
                     want.st, want.is_open, want.cnt, want.issued, want.waiting,
                     want.expired, want.reqno, want.blocked);
            $display("  got  st=%0d open=%0b cnt=%0d iss=%0b wait=%0b tmo=%0b req=%0d blk=%0h",
                     got.st, got.is_open, got.cnt, got.issued, got.waiting,
                     got.expired, got.reqno, got.blocked);
          end
        end
      end
    end
    if (hold_cycles > 0) begin
      // long hold-off: let the core back up into full
      hold_cycles--;
      pop <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(5, 120);
      end
      rx_left--;
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom);
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (rx_left % 5 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: threshold 2, timeout 800, window 3000, dedup 10.
  task automatic test_directed_defaults();
    paced = 1'b0;
    send_event(outcome_ev(erc_pkg::KIND_TICK, 32'd0, 16'h0000, erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(FUNC_SPARE, 32'd5, 16'h0000, erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd0, 16'h0000, erc_pkg::OC_SUCCESS));
    // same task and outcome inside the dedup window
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd5, 16'h0000, erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd20, 16'hFFFF, erc_pkg::OC_EXCEPTION));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd40, 16'h0007, erc_pkg::OC_UNKNOWN));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd100, 16'h0007, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd105, 16'h0007, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd120, 16'h0007, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd140, 16'h0007, erc_pkg::OC_EMPTY));
    // acks: bad status, wrong id, wrong task, then a full match
    send_event(ack_ev(32'd150, 16'h0007, 1'b0, 1'b0, 1'b0, 32'd0));
    send_event(ack_ev(32'd160, 16'h0007, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_event(ack_ev(32'd165, 16'h0003, 1'b1, 1'b1, 1'b0, 32'd0));
    send_event(ack_ev(32'd170, 16'h0007, 1'b1, 1'b1, 1'b1, req_id));
    // time going backwards: never a duplicate
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd50, 16'h0007, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd200, 16'h0009, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd300, 16'h0009, erc_pkg::OC_EMPTY));
    // ack arriving in the same word where the request expires
    send_event(ack_ev(32'd1200, 16'h0009, 1'b1, 1'b0, 1'b1, req_id));
    send_event(outcome_ev(erc_pkg::KIND_TICK, 32'd1210, 16'h0000, erc_pkg::OC_SUCCESS));
    send_event(ack_ev(32'd1220, 16'h0000, 1'b1, 1'b0, 1'b0, 32'd0));
    // reset window passes since the last counted empty
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd4000, 16'h0009, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'hFFFF_FFFF, 16'h0000,
                          erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd0, 16'h0000, erc_pkg::OC_EMPTY));
  endtask

  // All-zero registers: instant trip, instant expiry, no time reset, exact dedup.
  task automatic test_zero_settings();
    set_regs(8'd0, 16'd0, 16'd0, 16'd0);
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd1000, 16'h0001, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::KIND_TICK, 32'd1000, 16'h0000, erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd1000, 16'h0001, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd1001, 16'h0001, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd900000, 16'h0002, erc_pkg::OC_EMPTY));
    send_event(ack_ev(32'd900000, 16'h0002, 1'b1, 1'b1, 1'b1, req_id));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd900000, 16'h0002,
                          erc_pkg::OC_SUCCESS));
    send_event(outcome_ev(FUNC_SPARE, 32'd5, 16'h0000, erc_pkg::OC_SUCCESS));
  endtask

  // Largest and smallest legal settings.
  task automatic test_extreme_settings();
    set_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd0, 16'hFFFF, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd65535, 16'hFFFF, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd65536, 16'hFFFF, erc_pkg::OC_EMPTY));
    send_event(ack_ev(32'd65536, 16'hFFFF, 1'b1, 1'b0, 1'b1, 32'd0));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd200000, 16'hFFFF,
                          erc_pkg::OC_SUCCESS));
    // window of one: a blocked task is released while its request still waits
    set_regs(8'd1, 16'hFFFF, 16'd1, 16'd0);
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd10, 16'h0004, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd11, 16'h0006, erc_pkg::OC_SUCCESS));
    send_event(ack_ev(32'd12, 16'h0004, 1'b1, 1'b1, 1'b1, req_id));
    send_event(ack_ev(32'd12, 16'h0004, 1'b1, 1'b0, 1'b1, req_id));
    set_regs(8'd1, 16'd1, 16'd1, 16'd0);
    send_event(outcome_ev(erc_pkg::FUNC_OUTCOME, 32'd20, 16'h0004, erc_pkg::OC_EMPTY));
    send_event(outcome_ev(erc_pkg::KIND_TICK, 32'd21, 16'h0000, erc_pkg::OC_SUCCESS));
  endtask

  // Long streak up to the top threshold, across the signed time boundary.
  task automatic test_long_streak();
    int i;
    set_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'd0);
    paced   = 1'b1;
    wall_ms = 32'h7FFF_FF00;
    for (i = 0; i < 258; i++) begin
      wall_ms = wall_ms + 32'd1;
      send_paced(outcome_ev(erc_pkg::FUNC_OUTCOME, wall_ms, 16'h0005, erc_pkg::OC_EMPTY));
    end
    send_paced(ack_ev(wall_ms, 16'h0005, 1'b1, 1'b1, 1'b1, req_id));
  endtask

  // Random phases, each with its own settings and pacing.
  task automatic test_random_mix();
    int          p;
    int          i;
    logic [7:0]  th;
    logic [15:0] tmo;
    logic [15:0] win;
    logic [15:0] ddp;
    for (p = 0; p < 10; p++) begin
      th  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
      tmo = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 3000)) : 16'($urandom);
      win = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(100, 6000)) : 16'($urandom);
      ddp = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      if (tmo == '0) tmo = 16'd1;
      if (win == '0) win = 16'd1;
      set_regs(th, tmo, win, ddp);
      step_max   = (ddp > 200) ? 200 : ddp + 20;
      jump_max   = 2 * ((win > tmo) ? win : tmo) + 10;
      paced      = (p % 3 != 0);
      burst_left = 0;
      for (i = 0; i < 120; i++)
        send_paced(rand_event());
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so full must rise.
  task automatic test_backpressure();
    int i;
    settle();
    paced       = 1'b0;
    hold_cycles = 300;
    for (i = 0; i < 48; i++)
      send_event(rand_event());
    // pause until every word has come back, then resume briefly
    settle();
    for (i = 0; i < 10; i++)
      send_event(rand_event());
  endtask

  initial begin
    rst             <= 1'b1;
    push            <= 1'b0;
    func            <= erc_pkg::FUNC_OUTCOME;
    now_ms          <= '0;
    task_id         <= '0;
    outcome         <= erc_pkg::OC_SUCCESS;
    ack_ok          <= 1'b0;
    ack_has_task    <= 1'b0;
    ack_has_request <= 1'b0;
    ack_request_id  <= '0;
    pop             <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= erc_pkg::REG_EMPTY_THRESHOLD;
    cfg_data        <= '0;
    fails       = 0;
    hold_cycles = 0;
    rx_mode     = 0;
    rx_left     = 0;
    burst_left  = 0;
    paced       = 1'b0;
    wall_ms     = '0;
    step_max    = 20;
    jump_max    = 100;
    breaker_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_zero_settings();
    test_extreme_settings();
    test_long_streak();
    test_random_mix();
    test_backpressure();

    // drain, then wait for any stray word to show up
    settle();
    repeat (8) @(posedge clk);
    fails += verdicts.size();
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
